>>> hw/rtl/fse_pkg.sv
// Shared constants and helpers for the Fourier series evaluator.
// Depends on nothing; every other file of the block but fse_queue uses it.
package fse_pkg;

   localparam int COEF_BITS_DEF  = 32;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int SUM_BITS       = 48;
   localparam int PH_BITS        = 19;
   localparam int FRAC_BITS      = 16;
   localparam int TERMS          = 12;

   // Q2.16 phasor limits and unity
   localparam logic signed [PH_BITS-1:0] PH_ONE = 19'sd65536;
   localparam logic signed [PH_BITS-1:0] PH_MAX = 19'sd131071;
   localparam logic signed [PH_BITS-1:0] PH_MIN = -19'sd131072;

   // pi in Q60 and one in Q62 for the series engine
   localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
   localparam logic [63:0] HALF_Q16_IN_Q62 = 64'h0000_2000_0000_0000;

   // reciprocal of a term divisor: floor(x*m / 2^74) is floor(x/d) for any 64-bit x
   // and any d up to 1024
   localparam int RECIP_SHIFT = 74;
   localparam int RECIP_BITS  = 74;

   function automatic logic [RECIP_BITS-1:0] recip(input int d);
      logic [127:0] t;
      t = (128'(1) << RECIP_SHIFT) / 128'(d);
      return RECIP_BITS'(t + 128'(1));
   endfunction

   // term k divides by (2k-1)(2k) for cosine, (2k)(2k+1) for sine; entry zero unused
   localparam logic [RECIP_BITS-1:0] COS_RECIP [TERMS+1] = '{
      '0, recip(2), recip(12), recip(30), recip(56), recip(90), recip(132),
      recip(182), recip(240), recip(306), recip(380), recip(462), recip(552)};
   localparam logic [RECIP_BITS-1:0] SIN_RECIP [TERMS+1] = '{
      '0, recip(6), recip(20), recip(42), recip(72), recip(110), recip(156),
      recip(210), recip(272), recip(342), recip(420), recip(506), recip(600)};

endpackage

>>> hw/rtl/fse_req_if.sv
// Input channel of the evaluator: valid/ready plus one coefficient pair.
// Depends on fse_pkg for default widths.
interface fse_req_if #(
   parameter int COEF_BITS  = fse_pkg::COEF_BITS_DEF,
   parameter int ANGLE_BITS = fse_pkg::ANGLE_BITS_DEF
) ();
   logic                        valid;
   logic                        ready;
   logic [ANGLE_BITS-1:0]       angle;
   logic signed [COEF_BITS-1:0] coef_cos;
   logic signed [COEF_BITS-1:0] coef_sin;
   logic                        first_pair;
   logic                        last_pair;

   modport source (output valid, angle, coef_cos, coef_sin, first_pair, last_pair,
                   input ready);
   modport sink   (input valid, angle, coef_cos, coef_sin, first_pair, last_pair,
                   output ready);
endinterface

>>> hw/rtl/fse_rsp_if.sv
// Result channel of the evaluator: valid/ready plus the series value.
// Depends on fse_pkg for the sum width.
interface fse_rsp_if ();
   logic                                valid;
   logic                                ready;
   logic signed [fse_pkg::SUM_BITS-1:0] series_value;
   logic                                saturated;

   modport source (output valid, series_value, saturated, input ready);
   modport sink   (input valid, series_value, saturated, output ready);
endinterface

>>> hw/rtl/fourier_series_evaluator.sv
// Fourier series evaluator: sums a_k*cos(k*theta) + b_k*sin(k*theta) over a stream of
// coefficient beats, one beat per cycle while the front is idle and the queue has room.
// After a beat with first_pair set, no further beat is taken until the front's series
// unit has formed the rotation step: one shared 32x32 multiplier, four partial products a
// product and six a division by reciprocal multiplication, one of each per Taylor term
// of cosine and of sine over 12 terms; every other beat passes straight through. The back
// part turns a beat into its sum update in two stages, and the result register is loaded
// with the sum update of its last_pair beat. Depends on fse_pkg, fse_req_if, fse_rsp_if,
// fse_front, fse_queue and fse_back.
module fourier_series_evaluator #(
   parameter int COEF_BITS  = fse_pkg::COEF_BITS_DEF,
   parameter int ANGLE_BITS = fse_pkg::ANGLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   fse_req_if.sink    req,
   fse_rsp_if.source  rsp
);
   localparam int PB = fse_pkg::PH_BITS;
   localparam int QW = 2*COEF_BITS + 2 + 2*PB;

   logic                 f_valid, f_ready, b_valid, b_ready;
   logic [COEF_BITS-1:0] f_cc, f_cs, b_cc, b_cs;
   logic                 f_first, f_last, b_first, b_last;
   logic signed [PB-1:0] f_stc, f_sts, b_stc, b_sts;
   logic [QW-1:0]        q_in, q_out;

   fse_front #(.COEF_BITS(COEF_BITS), .ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .push_valid    (f_valid),
      .push_ready    (f_ready),
      .push_coef_cos (f_cc),
      .push_coef_sin (f_cs),
      .push_first    (f_first),
      .push_last     (f_last),
      .push_step_cos (f_stc),
      .push_step_sin (f_sts)
   );

   // queue entry packing
   assign q_in = {f_cc, f_cs, f_first, f_last, f_stc, f_sts};
   assign {b_cc, b_cs, b_first, b_last, b_stc, b_sts} = q_out;

   fse_queue #(.WIDTH(QW), .DEPTH(fse_pkg::QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_in),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (q_out)
   );

   fse_back #(.COEF_BITS(COEF_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (b_valid),
      .pop_ready    (b_ready),
      .pop_coef_cos (b_cc),
      .pop_coef_sin (b_cs),
      .pop_first    (b_first),
      .pop_last     (b_last),
      .pop_step_cos (b_stc),
      .pop_step_sin (b_sts),
      .rsp          (rsp)
   );
endmodule

>>> hw/rtl/fse_queue.sv
// Small FIFO between the front and back parts of the evaluator.
// Depends on nothing but its parameters.
module fse_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

>>> hw/rtl/fse_front.sv
// Front part: takes input beats, and on a start beat works out the rotation step
// (cosine and sine of the angle) with a shared multiplier; term divisions use reciprocals.
// Depends on fse_pkg and fse_req_if.
module fse_front #(
   parameter int COEF_BITS  = fse_pkg::COEF_BITS_DEF,
   parameter int ANGLE_BITS = fse_pkg::ANGLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   fse_req_if.sink                              req,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output logic [COEF_BITS-1:0]                 push_coef_cos,
   output logic [COEF_BITS-1:0]                 push_coef_sin,
   output logic                                 push_first,
   output logic                                 push_last,
   output logic signed [fse_pkg::PH_BITS-1:0]   push_step_cos,
   output logic signed [fse_pkg::PH_BITS-1:0]   push_step_sin
);
   localparam int NW = ANGLE_BITS - 2;
   localparam int PB = fse_pkg::PH_BITS;
   localparam int RB = fse_pkg::RECIP_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_X    = 3'd1;
   localparam logic [2:0] ST_X2   = 3'd2;
   localparam logic [2:0] ST_TCM  = 3'd3;
   localparam logic [2:0] ST_TCD  = 3'd4;
   localparam logic [2:0] ST_TSM  = 3'd5;
   localparam logic [2:0] ST_TSD  = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic [3:0]           k_ff, k_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [1:0]           quad_ff, quad_in;
   logic                 swap_ff, swap_in;
   logic [COEF_BITS-1:0] coef_c_ff, coef_c_in, coef_s_ff, coef_s_in;
   logic                 last_ff, last_in;
   logic [159:0]         acc_ff, acc_in;
   logic [63:0]          x2_ff, x2_in, tc_ff, tc_in, ts_ff, ts_in;
   logic [63:0]          sc_ff, sc_in, ss_ff, ss_in, quo_ff, quo_in;

   logic                 accept;
   logic [NW-1:0]        r_part, half_q;
   logic [NW:0]          q_size;
   logic [63:0]          mul_a, mul_b;
   logic [31:0]          a_half, b_half;
   logic [63:0]          pp;
   logic [1:0]           word_sh;
   logic [159:0]         pp_sh, acc_sum;
   logic [63:0]          prod_q62, quot;
   logic [RB-1:0]        recip_m;
   logic [63:0]          rnd_c, rnd_s;
   logic [16:0]          c_mag, s_mag;
   logic signed [PB-1:0] c_pos, s_pos;

   // octant reduction of the incoming angle
   assign r_part = req.angle[NW-1:0];
   assign half_q = NW'(1) << (NW - 1);
   assign q_size = (NW + 1)'(1) << NW;

   assign req.ready = (state_ff == ST_IDLE) && push_ready;
   assign accept    = req.valid && req.ready;

   // reciprocal of the divisor of the current term
   assign recip_m = (state_ff == ST_TSD) ? fse_pkg::SIN_RECIP[k_ff] : fse_pkg::COS_RECIP[k_ff];

   // 64x64 or 64x74 multiply, one 32x32 partial product a cycle
   always_comb begin
      case (state_ff)
         ST_X: begin
            mul_a = 64'(n_ff);
            mul_b = fse_pkg::PI_Q60;
         end
         ST_X2: begin
            mul_a = ts_ff;
            mul_b = ts_ff;
         end
         ST_TCM: begin
            mul_a = tc_ff;
            mul_b = x2_ff;
         end
         ST_TCD, ST_TSD: begin
            mul_a = quo_ff;
            mul_b = recip_m[63:0];
         end
         default: begin
            mul_a = ts_ff;
            mul_b = x2_ff;
         end
      endcase
   end

   assign a_half = cnt_ff[0] ? mul_a[63:32] : mul_a[31:0];

   always_comb begin
      case (cnt_ff[2:1])
         2'd0:    b_half = mul_b[31:0];
         2'd1:    b_half = mul_b[63:32];
         default: b_half = 32'(recip_m[RB-1:64]);
      endcase
   end

   assign pp      = 64'(a_half) * 64'(b_half);
   assign word_sh = 2'(cnt_ff[0]) + cnt_ff[2:1];

   always_comb begin
      case (word_sh)
         2'd0:    pp_sh = {96'd0, pp};
         2'd1:    pp_sh = {64'd0, pp, 32'd0};
         2'd2:    pp_sh = {32'd0, pp, 64'd0};
         default: pp_sh = {pp, 96'd0};
      endcase
   end

   assign acc_sum  = acc_ff + pp_sh;
   assign prod_q62 = acc_sum[62 +: 64];
   assign quot     = acc_sum[fse_pkg::RECIP_SHIFT +: 64];

   // round to Q2.16 and fold back to the quadrant
   assign rnd_c = sc_ff + fse_pkg::HALF_Q16_IN_Q62;
   assign rnd_s = ss_ff + fse_pkg::HALF_Q16_IN_Q62;
   assign c_mag = swap_ff ? rnd_s[62:46] : rnd_c[62:46];
   assign s_mag = swap_ff ? rnd_c[62:46] : rnd_s[62:46];
   assign c_pos = PB'(c_mag);
   assign s_pos = PB'(s_mag);

   always_comb begin
      case (quad_ff)
         2'd0: begin
            push_step_cos = c_pos;
            push_step_sin = s_pos;
         end
         2'd1: begin
            push_step_cos = -s_pos;
            push_step_sin = c_pos;
         end
         2'd2: begin
            push_step_cos = -c_pos;
            push_step_sin = -s_pos;
         end
         default: begin
            push_step_cos = s_pos;
            push_step_sin = -c_pos;
         end
      endcase
   end

   // beats to the queue: plain beats pass straight through, start beats after the step
   always_comb begin
      if (state_ff == ST_DONE) begin
         push_valid    = 1'b1;
         push_coef_cos = coef_c_ff;
         push_coef_sin = coef_s_ff;
         push_first    = 1'b1;
         push_last     = last_ff;
      end else begin
         push_valid    = (state_ff == ST_IDLE) && req.valid && !req.first_pair;
         push_coef_cos = req.coef_cos;
         push_coef_sin = req.coef_sin;
         push_first    = 1'b0;
         push_last     = req.last_pair;
      end
   end

   // series sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      n_in      = n_ff;
      quad_in   = quad_ff;
      swap_in   = swap_ff;
      coef_c_in = coef_c_ff;
      coef_s_in = coef_s_ff;
      last_in   = last_ff;
      acc_in    = acc_ff;
      x2_in     = x2_ff;
      tc_in     = tc_ff;
      ts_in     = ts_ff;
      sc_in     = sc_ff;
      ss_in     = ss_ff;
      quo_in    = quo_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req.first_pair) begin
               coef_c_in = req.coef_cos;
               coef_s_in = req.coef_sin;
               last_in   = req.last_pair;
               quad_in   = req.angle[ANGLE_BITS-1 -: 2];
               swap_in   = (r_part > half_q);
               n_in      = (r_part > half_q) ? NW'(q_size - (NW + 1)'(r_part)) : r_part;
               acc_in    = '0;
               cnt_in    = '0;
               state_in  = ST_X;
            end
         end
         ST_X, ST_X2, ST_TCM, ST_TSM: begin
            acc_in = acc_sum;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[1:0] == 2'd3) begin
               acc_in = '0;
               cnt_in = '0;
               case (state_ff)
                  ST_X: begin
                     ts_in    = acc_sum[ANGLE_BITS-3 +: 64];
                     ss_in    = acc_sum[ANGLE_BITS-3 +: 64];
                     tc_in    = fse_pkg::ONE_Q62;
                     sc_in    = fse_pkg::ONE_Q62;
                     state_in = ST_X2;
                  end
                  ST_X2: begin
                     x2_in    = prod_q62;
                     k_in     = 4'd1;
                     state_in = ST_TCM;
                  end
                  ST_TCM: begin
                     quo_in   = prod_q62;
                     state_in = ST_TCD;
                  end
                  default: begin
                     quo_in   = prod_q62;
                     state_in = ST_TSD;
                  end
               endcase
            end
         end
         // division by the term constant: six partial products with its reciprocal
         ST_TCD, ST_TSD: begin
            acc_in = acc_sum;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 3'd5) begin
               acc_in = '0;
               cnt_in = '0;
               if (state_ff == ST_TCD) begin
                  tc_in    = quot;
                  sc_in    = k_ff[0] ? sc_ff - quot : sc_ff + quot;
                  state_in = ST_TSM;
               end else begin
                  ts_in = quot;
                  ss_in = k_ff[0] ? ss_ff - quot : ss_ff + quot;
                  if (k_ff == 4'(fse_pkg::TERMS)) begin
                     state_in = ST_DONE;
                  end else begin
                     k_in     = k_ff + 1'b1;
                     state_in = ST_TCM;
                  end
               end
            end
         end
         ST_DONE: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      quad_ff   <= quad_in;
      swap_ff   <= swap_in;
      coef_c_ff <= coef_c_in;
      coef_s_ff <= coef_s_in;
      last_ff   <= last_in;
      acc_ff    <= acc_in;
      x2_ff     <= x2_in;
      tc_ff     <= tc_in;
      ts_ff     <= ts_in;
      sc_ff     <= sc_in;
      ss_ff     <= ss_in;
      quo_ff    <= quo_in;
   end
endmodule

>>> hw/rtl/fse_back.sv
// Back part: per coefficient pair, the two scaled products and the phasor rotation,
// then the saturating accumulate and the result register. Depends on fse_pkg, fse_rsp_if.
module fse_back #(
   parameter int COEF_BITS = fse_pkg::COEF_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  logic [COEF_BITS-1:0]                pop_coef_cos,
   input  logic [COEF_BITS-1:0]                pop_coef_sin,
   input  logic                                pop_first,
   input  logic                                pop_last,
   input  logic signed [fse_pkg::PH_BITS-1:0]  pop_step_cos,
   input  logic signed [fse_pkg::PH_BITS-1:0]  pop_step_sin,
   fse_rsp_if.source                           rsp
);
   localparam int PB  = fse_pkg::PH_BITS;
   localparam int SB  = fse_pkg::SUM_BITS;
   localparam int FB  = fse_pkg::FRAC_BITS;
   localparam int PRW = COEF_BITS + PB;
   localparam int TW  = ((SB > PRW - FB) ? SB : PRW - FB) + 2;

   localparam logic signed [TW-1:0] SUM_HI = TW'({1'b0, {(SB-1){1'b1}}});
   localparam logic signed [TW-1:0] SUM_LO = -SUM_HI - TW'(1);

   logic signed [PB-1:0]  pc_ff, pc_in, ps_ff, ps_in, stc_ff, stc_in, sts_ff, sts_in;
   logic signed [PRW-1:0] pa_ff, pb_ff, pa_in, pb_in;
   logic                  s1_valid_ff, s1_first_ff, s1_last_ff;
   logic signed [SB-1:0]  sum_ff, sum_in, out_val_ff;
   logic                  sat_ff, sat_in, out_sat_ff, out_valid_ff, out_valid_in;
   logic                  adv, pop;

   logic signed [PB-1:0]        pc_e, ps_e, stc_e, sts_e;
   logic signed [2*PB-1:0]      m_cc, m_ss, m_sc, m_cs;
   logic signed [2*PB:0]        nc_full, ns_full, nc_sh, ns_sh;
   logic signed [TW-1:0]        total;
   logic signed [SB-1:0]        sum_base;

   // stall only when a finished result cannot be placed
   assign adv       = !(s1_valid_ff && s1_last_ff && out_valid_ff && !rsp.ready);
   assign pop_ready = adv;
   assign pop       = pop_valid && adv;

   // stage one: products with the phasor of this harmonic, then rotate
   assign pc_e  = pop_first ? fse_pkg::PH_ONE : pc_ff;
   assign ps_e  = pop_first ? PB'(0) : ps_ff;
   assign stc_e = pop_first ? pop_step_cos : stc_ff;
   assign sts_e = pop_first ? pop_step_sin : sts_ff;

   assign pa_in = $signed(pop_coef_cos) * pc_e;
   assign pb_in = $signed(pop_coef_sin) * ps_e;

   assign m_cc = stc_e * pc_e;
   assign m_ss = sts_e * ps_e;
   assign m_sc = sts_e * pc_e;
   assign m_cs = stc_e * ps_e;
   assign nc_full = (2*PB+1)'(m_cc) - (2*PB+1)'(m_ss) + (2*PB+1)'(32768);
   assign ns_full = (2*PB+1)'(m_sc) + (2*PB+1)'(m_cs) + (2*PB+1)'(32768);
   assign nc_sh   = nc_full >>> FB;
   assign ns_sh   = ns_full >>> FB;

   always_comb begin
      pc_in  = pc_ff;
      ps_in  = ps_ff;
      stc_in = stc_ff;
      sts_in = sts_ff;
      if (pop) begin
         stc_in = stc_e;
         sts_in = sts_e;
         if (nc_sh > (2*PB+1)'(fse_pkg::PH_MAX)) begin
            pc_in = fse_pkg::PH_MAX;
         end else if (nc_sh < (2*PB+1)'(fse_pkg::PH_MIN)) begin
            pc_in = fse_pkg::PH_MIN;
         end else begin
            pc_in = nc_sh[PB-1:0];
         end
         if (ns_sh > (2*PB+1)'(fse_pkg::PH_MAX)) begin
            ps_in = fse_pkg::PH_MAX;
         end else if (ns_sh < (2*PB+1)'(fse_pkg::PH_MIN)) begin
            ps_in = fse_pkg::PH_MIN;
         end else begin
            ps_in = ns_sh[PB-1:0];
         end
      end
   end

   // stage two: saturating accumulate
   assign sum_base = s1_first_ff ? SB'(0) : sum_ff;
   assign total = TW'(sum_base) + TW'($signed(pa_ff[PRW-1:FB]))
                + TW'($signed(pb_ff[PRW-1:FB]));

   always_comb begin
      sum_in = sum_ff;
      sat_in = sat_ff;
      if (s1_valid_ff && adv) begin
         sat_in = s1_first_ff ? 1'b0 : sat_ff;
         if (total > SUM_HI) begin
            sum_in = SUM_HI[SB-1:0];
            sat_in = 1'b1;
         end else if (total < SUM_LO) begin
            sum_in = SUM_LO[SB-1:0];
            sat_in = 1'b1;
         end else begin
            sum_in = total[SB-1:0];
         end
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      if (s1_valid_ff && s1_last_ff && adv) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= fse_pkg::PH_ONE;
         ps_ff        <= '0;
         stc_ff       <= fse_pkg::PH_ONE;
         sts_ff       <= '0;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         ps_ff        <= ps_in;
         stc_ff       <= stc_in;
         sts_ff       <= sts_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
         if (adv) begin
            s1_valid_ff <= pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pa_ff       <= pa_in;
         pb_ff       <= pb_in;
         s1_first_ff <= pop_first;
         s1_last_ff  <= pop_last;
      end
      if (s1_valid_ff && s1_last_ff && adv) begin
         out_val_ff <= sum_in;
         out_sat_ff <= sat_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.series_value = out_val_ff;
   assign rsp.saturated    = out_sat_ff;
endmodule

>>> bench/tb.sv
// Testbench for fourier_series_evaluator: streams coefficient beats, predicts each
// series sum with a local fixed-point model and checks every result beat.
// Depends on fse_pkg, fse_req_if, fse_rsp_if and the evaluator RTL.
module tb;

   typedef struct packed {
      logic [fse_pkg::SUM_BITS-1:0] value;
      logic                         sat;
   } series_type;

   logic clock;
   logic reset;
   bit   idle_on;
   int   fail_count;
   int   mismatch_count;
   int   beats_sent;
   series_type pending_sums[$];

   // evaluator state mirror
   longint acc_sum, ph_c, ph_s, st_c, st_s;
   bit     acc_sat;

   fse_req_if req ();
   fse_rsp_if rsp ();

   fourier_series_evaluator u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Q62 product, top bits kept
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[125:62];
   endfunction

   // cos and sin of one octant angle by Taylor series, Q62
   function automatic void octant_trig(input logic [63:0] n, output logic [63:0] c,
                                       output logic [63:0] s);
      logic [127:0] p;
      logic [63:0]  x, x2, tc, ts;
      p = 128'(n) * 128'(fse_pkg::PI_Q60);
      x = p[76:13];
      x2 = mul_q62(x, x);
      tc = fse_pkg::ONE_Q62; c = fse_pkg::ONE_Q62;
      ts = x; s = x;
      for (int k = 1; k <= fse_pkg::TERMS; k++) begin
         tc = mul_q62(tc, x2) / 64'((2 * k - 1) * (2 * k));
         ts = mul_q62(ts, x2) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            c = c - tc; s = s - ts;
         end else begin
            c = c + tc; s = s + ts;
         end
      end
   endfunction

   function automatic longint round_q62_to_q16(input logic [63:0] v);
      logic [63:0] r;
      r = (v + 64'h0000_2000_0000_0000) >> 46;
      return longint'(r);
   endfunction

   // rotation step of an angle, by quadrant and octant symmetry
   function automatic void load_step(input logic [15:0] ang);
      logic [1:0]  quad;
      logic [13:0] r;
      logic [63:0] c, s;
      longint      c0, s0;
      quad = ang[15:14];
      r = ang[13:0];
      if (r > 14'h2000) begin
         octant_trig(64'h4000 - 64'(r), c, s);
         c0 = round_q62_to_q16(s); s0 = round_q62_to_q16(c);
      end else begin
         octant_trig(64'(r), c, s);
         c0 = round_q62_to_q16(c); s0 = round_q62_to_q16(s);
      end
      case (quad)
         2'd0: begin st_c = c0;  st_s = s0;  end
         2'd1: begin st_c = -s0; st_s = c0;  end
         2'd2: begin st_c = -c0; st_s = -s0; end
         default: begin st_c = s0; st_s = -c0; end
      endcase
   endfunction

   function automatic longint clamp_phasor(input longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   // one accepted beat into the mirror; a last beat queues its sum
   function automatic void accumulate_pair(input logic [15:0] ang, input logic signed [31:0] a,
                                           input logic signed [31:0] b, input bit f, input bit l);
      longint sum, nc, ns;
      series_type e;
      if (f) begin
         load_step(ang);
         ph_c = 65536; ph_s = 0; acc_sum = 0; acc_sat = 0;
      end
      sum = acc_sum + ((longint'(a) * ph_c) >>> 16) + ((longint'(b) * ph_s) >>> 16);
      if (sum > 64'sh0000_7FFF_FFFF_FFFF) begin
         sum = 64'sh0000_7FFF_FFFF_FFFF; acc_sat = 1;
      end
      if (sum < -64'sh0000_8000_0000_0000) begin
         sum = -64'sh0000_8000_0000_0000; acc_sat = 1;
      end
      acc_sum = sum;
      nc = (st_c * ph_c - st_s * ph_s + 32768) >>> 16;
      ns = (st_s * ph_c + st_c * ph_s + 32768) >>> 16;
      ph_c = clamp_phasor(nc);
      ph_s = clamp_phasor(ns);
      if (l) begin
         e.value = acc_sum[fse_pkg::SUM_BITS-1:0];
         e.sat = acc_sat;
         pending_sums.push_back(e);
      end
   endfunction

   // drive one beat and wait for it to be taken; valid stays high afterwards
   task automatic send_pair(input logic [15:0] ang, input logic signed [31:0] a,
                            input logic signed [31:0] b, input bit f, input bit l);
      if (idle_on) begin
         while ($urandom_range(99) < 21) begin
            req.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req.valid <= 1'b1;
      req.angle <= ang;
      req.coef_cos <= a;
      req.coef_sin <= b;
      req.first_pair <= f;
      req.last_pair <= l;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      accumulate_pair(ang, a, b, f, l);
      beats_sent++;
   endtask

   function automatic logic signed [31:0] rand_coef();
      case ($urandom_range(3))
         0: return $signed($urandom_range(0, 131071)) - 65536;
         1: return $signed($urandom_range(0, 255)) - 128;
         default: return $urandom();
      endcase
   endfunction

   // result side: ready idling and compare against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= idle_on ? ($urandom_range(99) >= 21) : 1'b1;
      end
   end

   always @(posedge clock) begin
      series_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_sums.size() == 0) begin
            fail_count++;
            if (mismatch_count < 10)
               $display("unexpected result beat: value=%0d sat=%0b",
                        rsp.series_value, rsp.saturated);
            mismatch_count++;
         end else begin
            e = pending_sums.pop_front();
            if (rsp.series_value !== e.value || rsp.saturated !== e.sat) begin
               fail_count++;
               if (mismatch_count < 10)
                  $display("sum mismatch: exp value=%0d sat=%0b got value=%0d sat=%0b",
                           $signed(e.value), e.sat, rsp.series_value, rsp.saturated);
               mismatch_count++;
            end
         end
      end
   end

   // beats before any start, then extremes, quadrant corners, one-term series
   task automatic test_directed();
      logic [15:0] corners [8];
      corners = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000,
                  16'h2001, 16'h1FFF};
      send_pair(16'h1234, 32'sd65536, 32'sd65536, 1'b0, 1'b0);
      send_pair(16'h0000, 32'sh7FFF_FFFF, -32'sd1, 1'b0, 1'b1);
      foreach (corners[i]) begin
         send_pair(corners[i], 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b0);
         send_pair(16'h0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b1);
      end
      // continuing after an emit keeps sum and phasor
      send_pair(16'h0, 32'sd65536, 32'sd0, 1'b0, 1'b1);
      // first and last on the same beat
      send_pair(16'hAAAA, -32'sd65536, 32'sd12345, 1'b1, 1'b1);
      send_pair(16'h5555, 32'sd0, 32'sd0, 1'b1, 1'b1);
   endtask

   // long runs of full-scale coefficients at angle zero push the sum far out both ways
   task automatic test_full_scale();
      idle_on = 1'b0;
      for (int sgn = 0; sgn < 2; sgn++) begin
         send_pair(16'h0, sgn ? 32'sh8000_0000 : 32'sh7FFF_FFFF, 32'sd0, 1'b1, 1'b0);
         for (int i = 0; i < 60; i++)
            send_pair(16'h0, sgn ? 32'sh8000_0000 : 32'sh7FFF_FFFF, rand_coef(), 1'b0, 1'b0);
         send_pair(16'h0, 32'sd5, 32'sd5, 1'b0, 1'b1);
      end
      idle_on = 1'b1;
   endtask

   // mostly well-formed series of random length, some broken sequences
   task automatic test_random();
      int n, quota;
      quota = beats_sent + 1250;
      while (beats_sent < quota) begin
         if ($urandom_range(9) == 0) begin
            send_pair(16'($urandom()), rand_coef(), rand_coef(), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
         end else begin
            n = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
               send_pair(16'($urandom()), rand_coef(), rand_coef(), k == 0, k == n - 1);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      idle_on = 1'b1;
      req.valid = 1'b0;
      req.angle = '0;
      req.coef_cos = '0;
      req.coef_sin = '0;
      req.first_pair = 1'b0;
      req.last_pair = 1'b0;
      acc_sum = 0; ph_c = 65536; ph_s = 0; st_c = 65536; st_s = 0; acc_sat = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_scale();
      idle_on = 1'b0;
      repeat (200) send_pair(16'($urandom()), rand_coef(), rand_coef(),
                             1'($urandom_range(1)), 1'b1);
      idle_on = 1'b1;
      test_random();
      req.valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #(8 * 2000000);
      $display("FAIL");
      $finish;
   end
endmodule

>>> sim.f
hw/rtl/fse_pkg.sv
hw/rtl/fse_req_if.sv
hw/rtl/fse_rsp_if.sv
hw/rtl/fse_queue.sv
hw/rtl/fse_front.sv
hw/rtl/fse_back.sv
hw/rtl/fourier_series_evaluator.sv
bench/tb.sv
